// ===== sv/gfc_pkg.sv =====
// Shared types, codes and constants for the GIF frame compositor.
// Used by the front, back, top level and checker; has no dependencies of its own.
package gfc_pkg;

    // Default geometry and palette depth
    localparam int MAX_WIDTH_DEF    = 256;
    localparam int MAX_HEIGHT_DEF   = 256;
    localparam int PALETTE_SIZE_DEF = 256;

    // Command queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 4;

    // Stream widths
    localparam int IN_DATA_W  = 88;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 8;

    // Configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int CFG_W      = 9;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_CANVAS_WIDTH  = 2'd0;
    localparam logic [1:0] REG_CANVAS_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BACKGROUND    = 2'd2;

    localparam logic [CFG_W-1:0] CANVAS_WIDTH_RST  = 9'd256;
    localparam logic [CFG_W-1:0] CANVAS_HEIGHT_RST = 9'd256;
    localparam logic [CFG_W-1:0] BACKGROUND_RST    = 9'h1FF;

    // Input item modes
    localparam logic [2:0] MODE_CLEAR   = 3'd0;
    localparam logic [2:0] MODE_PALETTE = 3'd1;
    localparam logic [2:0] MODE_HEADER  = 3'd2;
    localparam logic [2:0] MODE_PIXEL   = 3'd3;
    localparam logic [2:0] MODE_READ    = 3'd4;

    // Back-end command kinds
    typedef logic [1:0] t_kind;
    localparam t_kind CMD_CLEAR = 2'd0;
    localparam t_kind CMD_PAL   = 2'd1;
    localparam t_kind CMD_WRITE = 2'd2;
    localparam t_kind CMD_READ  = 2'd3;

    // Luma weights in Q16 plus rounding term
    localparam logic [15:0] LUMA_R     = 16'd19661;
    localparam logic [15:0] LUMA_G     = 16'd38666;
    localparam logic [15:0] LUMA_B     = 16'd7209;
    localparam logic [24:0] LUMA_ROUND = 25'd256;

    // One queued command; the canvas address travels beside it
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;    // pixel index, fill index or palette index
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [8:0]  active;  // palette size at readout time
        logic        last;    // final canvas pixel of a readout
    } t_cmd;

    // Canvas dimension as used: 0 reads as 1, large values clamp to max
    function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int max_dim);
        int d;
        d = int'(v);
        if (d == 0) return 1;
        if (d > max_dim) return max_dim;
        return d;
    endfunction

endpackage

// ===== sv/gfc_ram.sv =====
// Generic single-port RAM with registered read and an access enable.
// No dependencies.
module gfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Read-before-write; output holds while disabled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule

// ===== sv/gfc_queue.sv =====
// Small flip-flop FIFO that decouples the front from the back.
// Depends on nothing but its parameters.
module gfc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW:0]      r_wr;
    logic [PW:0]      r_rd;

    assign o_valid = (r_wr != r_rd);
    assign o_full  = (r_wr[PW] != r_rd[PW]) && (r_wr[PW-1:0] == r_rd[PW-1:0]);
    assign o_data  = r_mem[r_rd[PW-1:0]];

    // Pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push && !o_full) r_wr <= r_wr + 1'b1;
            if (i_pop && o_valid)  r_rd <= r_rd + 1'b1;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr[PW-1:0]] <= i_data;
        end
    end

endmodule

// ===== sv/gfc_front.sv =====
// Front end: configuration registers, input acceptance, frame and readout
// raster state, and command generation. Uses gfc_pkg.
module gfc_front #(
    parameter int MAX_WIDTH    = gfc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT   = gfc_pkg::MAX_HEIGHT_DEF,
    parameter int PALETTE_SIZE = gfc_pkg::PALETTE_SIZE_DEF,
    parameter int ADDR_W       = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gfc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [gfc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [gfc_pkg::APB_DATA_W-1:0]  prdata,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [gfc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic [gfc_pkg::IN_USER_W-1:0]   s_axis_tuser,
    // to queue / from back
    input  logic                            i_q_full,
    input  logic                            i_back_busy,
    output logic                            o_push,
    output gfc_pkg::t_cmd                   o_push_cmd,
    output logic [ADDR_W-1:0]               o_push_addr
);

    localparam int CWW = $clog2(MAX_WIDTH + 1);
    localparam int CHW = $clog2(MAX_HEIGHT + 1);
    localparam int DCW = $clog2(ADDR_W + 1);

    // Input fields
    logic [7:0] f_value, f_red, f_green, f_blue, f_ox, f_oy;
    logic [8:0] f_fw, f_fh, f_tidx, f_pcolors;
    logic       f_replace;

    assign f_value   = s_axis_tdata[7:0];
    assign f_red     = s_axis_tdata[15:8];
    assign f_green   = s_axis_tdata[23:16];
    assign f_blue    = s_axis_tdata[31:24];
    assign f_fw      = s_axis_tdata[40:32];
    assign f_fh      = s_axis_tdata[49:41];
    assign f_ox      = s_axis_tdata[57:50];
    assign f_oy      = s_axis_tdata[65:58];
    assign f_tidx    = s_axis_tdata[74:66];
    assign f_replace = s_axis_tdata[75];
    assign f_pcolors = s_axis_tdata[84:76];

    // Registers
    logic [8:0]        r_cfg_w, r_cfg_h, r_cfg_bg;
    logic [8:0]        r_fw, n_fw, r_fh, n_fh;
    logic [7:0]        r_ox, n_ox, r_oy, n_oy;
    logic              r_has_key, n_has_key, r_replace, n_replace;
    logic [7:0]        r_key, n_key;
    logic [8:0]        r_active, n_active;
    logic [8:0]        r_wx, n_wx, r_wy, n_wy;
    logic [ADDR_W-1:0] r_pos, n_pos;
    logic [CWW-1:0]    r_rx, n_rx;
    logic [CHW-1:0]    r_ry, n_ry;
    // position divider, run after a canvas size change
    logic              r_div_busy, n_div_busy;
    logic [DCW-1:0]    r_div_cnt, n_div_cnt;
    logic [ADDR_W-1:0] r_div_q, n_div_q;
    logic [CWW-1:0]    r_div_rem, n_div_rem;

    logic [CWW-1:0] cw;
    logic [CHW-1:0] ch;
    logic           accept, cfg_wr;
    logic [1:0]     cfg_idx;
    logic [9:0]     cx, cy;
    logic           px_live, in_canvas, keep, rd_last;
    logic [7:0]     fill;
    logic [CWW:0]   div_t;

    assign cw      = CWW'(gfc_pkg::clamp_dim(r_cfg_w, MAX_WIDTH));
    assign ch      = CHW'(gfc_pkg::clamp_dim(r_cfg_h, MAX_HEIGHT));
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    assign s_axis_tready = !i_q_full && !i_back_busy && !r_div_busy;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Configuration write and readback
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w  <= gfc_pkg::CANVAS_WIDTH_RST;
            r_cfg_h  <= gfc_pkg::CANVAS_HEIGHT_RST;
            r_cfg_bg <= gfc_pkg::BACKGROUND_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                gfc_pkg::REG_CANVAS_WIDTH:  r_cfg_w  <= pwdata[8:0];
                gfc_pkg::REG_CANVAS_HEIGHT: r_cfg_h  <= pwdata[8:0];
                gfc_pkg::REG_BACKGROUND:    r_cfg_bg <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            gfc_pkg::REG_CANVAS_WIDTH:  prdata = 32'(r_cfg_w);
            gfc_pkg::REG_CANVAS_HEIGHT: prdata = 32'(r_cfg_h);
            gfc_pkg::REG_BACKGROUND:    prdata = 32'(r_cfg_bg);
            default:                    prdata = '0;
        endcase
    end

    // Frame pixel placement
    assign cx        = 10'(r_ox) + 10'(r_wx);
    assign cy        = 10'(r_oy) + 10'(r_wy);
    assign px_live   = (r_fw != '0) && (r_fh != '0) && (r_wy < r_fh);
    assign in_canvas = (32'(cx) < 32'(cw)) && (32'(cy) < 32'(ch));
    assign keep      = r_has_key && (f_value == r_key) && !r_replace;
    assign fill      = r_cfg_bg[8] ? 8'd0 : r_cfg_bg[7:0];
    assign rd_last   = (r_rx == cw - 1'b1) && (r_ry == ch - 1'b1);
    assign div_t     = {r_div_rem, r_div_q[ADDR_W-1]};

    // Item handling and divider sequencing
    always_comb begin
        n_fw       = r_fw;
        n_fh       = r_fh;
        n_ox       = r_ox;
        n_oy       = r_oy;
        n_has_key  = r_has_key;
        n_key      = r_key;
        n_replace  = r_replace;
        n_active   = r_active;
        n_wx       = r_wx;
        n_wy       = r_wy;
        n_pos      = r_pos;
        n_rx       = r_rx;
        n_ry       = r_ry;
        n_div_busy = r_div_busy;
        n_div_cnt  = r_div_cnt;
        n_div_q    = r_div_q;
        n_div_rem  = r_div_rem;
        o_push      = 1'b0;
        o_push_cmd  = '0;
        o_push_addr = '0;

        if (accept) begin
            unique case (s_axis_tuser)
                gfc_pkg::MODE_CLEAR: begin
                    o_push          = 1'b1;
                    o_push_cmd.kind = gfc_pkg::CMD_CLEAR;
                    o_push_cmd.data = fill;
                    n_pos = '0;
                    n_rx  = '0;
                    n_ry  = '0;
                end
                gfc_pkg::MODE_PALETTE: begin
                    if (32'(f_value) < PALETTE_SIZE) begin
                        o_push           = 1'b1;
                        o_push_cmd.kind  = gfc_pkg::CMD_PAL;
                        o_push_cmd.data  = f_value;
                        o_push_cmd.red   = f_red;
                        o_push_cmd.green = f_green;
                        o_push_cmd.blue  = f_blue;
                    end
                end
                gfc_pkg::MODE_HEADER: begin
                    n_fw      = f_fw;
                    n_fh      = f_fh;
                    n_ox      = f_ox;
                    n_oy      = f_oy;
                    n_has_key = !f_tidx[8];
                    n_key     = f_tidx[7:0];
                    n_replace = f_replace;
                    n_active  = f_pcolors;
                    n_wx  = '0;
                    n_wy  = '0;
                    n_pos = '0;
                    n_rx  = '0;
                    n_ry  = '0;
                end
                gfc_pkg::MODE_PIXEL: begin
                    if (px_live) begin
                        if (in_canvas && !keep) begin
                            o_push          = 1'b1;
                            o_push_cmd.kind = gfc_pkg::CMD_WRITE;
                            o_push_cmd.data = f_value;
                            o_push_addr     = ADDR_W'(int'(cy) * MAX_WIDTH + int'(cx));
                        end
                        if (r_wx + 1'b1 >= r_fw) begin
                            n_wx = '0;
                            n_wy = r_wy + 1'b1;
                        end else begin
                            n_wx = r_wx + 1'b1;
                        end
                    end
                end
                gfc_pkg::MODE_READ: begin
                    o_push            = 1'b1;
                    o_push_cmd.kind   = gfc_pkg::CMD_READ;
                    o_push_cmd.active = r_active;
                    o_push_cmd.last   = rd_last;
                    o_push_addr       = ADDR_W'(int'(r_ry) * MAX_WIDTH + int'(r_rx));
                    if (rd_last) begin
                        n_pos = '0;
                        n_rx  = '0;
                        n_ry  = '0;
                    end else begin
                        n_pos = r_pos + 1'b1;
                        if (r_rx == cw - 1'b1) begin
                            n_rx = '0;
                            n_ry = r_ry + 1'b1;
                        end else begin
                            n_rx = r_rx + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end

        // Restoring division of the readout position by the canvas width
        if (cfg_wr && (cfg_idx == gfc_pkg::REG_CANVAS_WIDTH ||
                       cfg_idx == gfc_pkg::REG_CANVAS_HEIGHT)) begin
            n_div_busy = 1'b1;
            n_div_cnt  = '0;
            n_div_q    = r_pos;
            n_div_rem  = '0;
        end else if (r_div_busy) begin
            if (r_div_cnt != DCW'(ADDR_W)) begin
                n_div_cnt = r_div_cnt + 1'b1;
                if (div_t >= {1'b0, cw}) begin
                    n_div_rem = CWW'(div_t - {1'b0, cw});
                    n_div_q   = ADDR_W'({r_div_q, 1'b1});
                end else begin
                    n_div_rem = CWW'(div_t);
                    n_div_q   = ADDR_W'({r_div_q, 1'b0});
                end
            end else begin
                // stale position past the canvas end restarts at zero
                n_div_busy = 1'b0;
                if (32'(r_div_q) >= 32'(ch)) begin
                    n_pos = '0;
                    n_rx  = '0;
                    n_ry  = '0;
                end else begin
                    n_rx = r_div_rem;
                    n_ry = CHW'(r_div_q);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw       <= '0;
            r_fh       <= '0;
            r_ox       <= '0;
            r_oy       <= '0;
            r_has_key  <= 1'b0;
            r_key      <= '0;
            r_replace  <= 1'b0;
            r_active   <= '0;
            r_wx       <= '0;
            r_wy       <= '0;
            r_pos      <= '0;
            r_rx       <= '0;
            r_ry       <= '0;
            r_div_busy <= 1'b0;
            r_div_cnt  <= '0;
        end else begin
            r_fw       <= n_fw;
            r_fh       <= n_fh;
            r_ox       <= n_ox;
            r_oy       <= n_oy;
            r_has_key  <= n_has_key;
            r_key      <= n_key;
            r_replace  <= n_replace;
            r_active   <= n_active;
            r_wx       <= n_wx;
            r_wy       <= n_wy;
            r_pos      <= n_pos;
            r_rx       <= n_rx;
            r_ry       <= n_ry;
            r_div_busy <= n_div_busy;
            r_div_cnt  <= n_div_cnt;
        end
    end

    // Divider datapath
    always_ff @(posedge i_clk) begin
        r_div_q   <= n_div_q;
        r_div_rem <= n_div_rem;
    end

endmodule

// ===== sv/gfc_back.sv =====
// Back end: canvas and palette memories, clear sweep, luma computation and
// the readout pipeline with its output register. Uses gfc_pkg and gfc_ram.
module gfc_back #(
    parameter int MAX_WIDTH    = gfc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT   = gfc_pkg::MAX_HEIGHT_DEF,
    parameter int PALETTE_SIZE = gfc_pkg::PALETTE_SIZE_DEF,
    parameter int ADDR_W       = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  gfc_pkg::t_cmd                  i_q_cmd,
    input  logic [ADDR_W-1:0]              i_q_addr,
    output logic                           o_q_pop,
    output logic                           o_busy,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [gfc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tlast
);

    localparam int CANVAS_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int PAW          = $clog2(PALETTE_SIZE);
    localparam int SWEEP_DEPTH  = (CANVAS_DEPTH > PALETTE_SIZE) ? CANVAS_DEPTH : PALETTE_SIZE;
    localparam int SW           = $clog2(SWEEP_DEPTH);

    // Sweep state
    logic          r_sweep, r_init;
    logic [SW-1:0] r_cnt;
    logic [7:0]    r_fill;
    // Stage 1: canvas data available
    logic                  r_s1_valid;
    gfc_pkg::t_kind        r_s1_kind;
    logic [7:0]            r_s1_idx;
    logic [23:0]           r_s1_pr, r_s1_pg, r_s1_pb;
    logic [8:0]            r_s1_active;
    logic                  r_s1_last;
    // Stage 2: palette data available
    logic                  r_s2_valid, r_s2_ok, r_s2_last;
    // Output register
    logic                  r_out_valid, r_out_last;
    logic [7:0]            r_out_gray;

    logic              adv, sweep_last;
    logic              c_we, p_en, p_we;
    logic [ADDR_W-1:0] c_addr;
    logic [7:0]        c_wdata, c_rdata;
    logic [PAW-1:0]    p_addr;
    logic [7:0]        p_wdata, p_rdata;
    logic [24:0]       luma_sum;
    logic              s1_ok;

    assign adv        = !r_out_valid || m_axis_tready;
    assign sweep_last = (r_cnt == SW'(SWEEP_DEPTH - 1));
    assign o_q_pop    = adv && !r_sweep && i_q_valid;
    assign o_busy     = r_init;

    // Canvas port: sweep fill or queued pixel write / readout fetch
    always_comb begin
        if (r_sweep) begin
            c_we    = (32'(r_cnt) < CANVAS_DEPTH);
            c_addr  = r_cnt[ADDR_W-1:0];
            c_wdata = r_fill;
        end else begin
            c_we    = i_q_valid && (i_q_cmd.kind == gfc_pkg::CMD_WRITE);
            c_addr  = i_q_addr;
            c_wdata = i_q_cmd.data;
        end
    end

    gfc_ram #(
        .WIDTH (8),
        .DEPTH (CANVAS_DEPTH)
    ) u_canvas (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_we    (c_we),
        .i_addr  (c_addr),
        .i_wdata (c_wdata),
        .o_rdata (c_rdata)
    );

    // Palette port: reset clearing, gray write, or lookup of canvas index
    assign luma_sum = 25'(r_s1_pr) + 25'(r_s1_pg) + 25'(r_s1_pb) + gfc_pkg::LUMA_ROUND;
    assign s1_ok    = ({1'b0, c_rdata} < r_s1_active) && (32'(c_rdata) < PALETTE_SIZE);

    always_comb begin
        if (r_init) begin
            p_en    = 1'b1;
            p_we    = (32'(r_cnt) < PALETTE_SIZE);
            p_addr  = r_cnt[PAW-1:0];
            p_wdata = '0;
        end else begin
            p_en    = adv;
            p_we    = r_s1_valid && (r_s1_kind == gfc_pkg::CMD_PAL);
            p_addr  = (r_s1_kind == gfc_pkg::CMD_PAL) ? r_s1_idx[PAW-1:0] : c_rdata[PAW-1:0];
            p_wdata = luma_sum[23:16];
        end
    end

    gfc_ram #(
        .WIDTH (8),
        .DEPTH (PALETTE_SIZE)
    ) u_palette (
        .i_clk   (i_clk),
        .i_en    (p_en),
        .i_we    (p_we),
        .i_addr  (p_addr),
        .i_wdata (p_wdata),
        .o_rdata (p_rdata)
    );

    // Control: sweep, stage valids, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep     <= 1'b1;
            r_init      <= 1'b1;
            r_cnt       <= '0;
            r_fill      <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            if (r_sweep) begin
                r_cnt <= r_cnt + 1'b1;
                if (sweep_last) begin
                    r_sweep <= 1'b0;
                    r_init  <= 1'b0;
                end
            end else if (o_q_pop && i_q_cmd.kind == gfc_pkg::CMD_CLEAR) begin
                r_sweep <= 1'b1;
                r_cnt   <= '0;
                r_fill  <= i_q_cmd.data;
            end
            r_s1_valid  <= o_q_pop && (i_q_cmd.kind == gfc_pkg::CMD_PAL ||
                                       i_q_cmd.kind == gfc_pkg::CMD_READ);
            r_s2_valid  <= r_s1_valid && (r_s1_kind == gfc_pkg::CMD_READ);
            r_out_valid <= r_s2_valid;
        end
    end

    // Datapath stages
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_kind   <= i_q_cmd.kind;
            r_s1_idx    <= i_q_cmd.data;
            r_s1_pr     <= 24'(gfc_pkg::LUMA_R) * 24'(i_q_cmd.red);
            r_s1_pg     <= 24'(gfc_pkg::LUMA_G) * 24'(i_q_cmd.green);
            r_s1_pb     <= 24'(gfc_pkg::LUMA_B) * 24'(i_q_cmd.blue);
            r_s1_active <= i_q_cmd.active;
            r_s1_last   <= i_q_cmd.last;
            r_s2_ok     <= s1_ok;
            r_s2_last   <= r_s1_last;
            r_out_gray  <= r_s2_ok ? p_rdata : 8'd0;
            r_out_last  <= r_s2_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_gray;
    assign m_axis_tlast  = r_out_last;

endmodule

// ===== sv/gif_frame_compositor_to_gray.sv =====
// Readout: each gray result passes through the command queue, the canvas read,
// the palette read and the output register. Throughput: one item per cycle while the
// queue has room and neither the reset clearing nor a divider run is busy; a clear
// holds later items in the queue while the canvas port is swept.
// Reset: s_axis_tready stays low while canvas and palette are cleared; a canvas
// width or height write holds s_axis_tready low while the position divider runs.
module gif_frame_compositor_to_gray #(
    parameter int MAX_WIDTH    = gfc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT   = gfc_pkg::MAX_HEIGHT_DEF,
    parameter int PALETTE_SIZE = gfc_pkg::PALETTE_SIZE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // APB configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gfc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [gfc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [gfc_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    // input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // value, red, green, blue, frm_w, frm_h, offset_x, offset_y,
    // transparent_index, replace_disposal, palette_colors, zero pad
    input  logic [gfc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // mode
    input  logic [gfc_pkg::IN_USER_W-1:0]  s_axis_tuser,
    // output stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // gray
    output logic [gfc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // last_pixel
    output logic                           m_axis_tlast
);

    localparam int CANVAS_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W       = (CANVAS_DEPTH > 1) ? $clog2(CANVAS_DEPTH) : 1;
    localparam int CMD_W        = $bits(gfc_pkg::t_cmd);
    localparam int QW           = CMD_W + ADDR_W;

    logic              push, q_full, q_valid, q_pop, back_busy;
    gfc_pkg::t_cmd     push_cmd;
    logic [ADDR_W-1:0] push_addr;
    logic [QW-1:0]     q_out;

    assign pready = 1'b1;

    gfc_front #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .PALETTE_SIZE (PALETTE_SIZE),
        .ADDR_W       (ADDR_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_full      (q_full),
        .i_back_busy   (back_busy),
        .o_push        (push),
        .o_push_cmd    (push_cmd),
        .o_push_addr   (push_addr)
    );

    gfc_queue #(
        .WIDTH (QW),
        .DEPTH (gfc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_addr, push_cmd}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    gfc_back #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .PALETTE_SIZE (PALETTE_SIZE),
        .ADDR_W       (ADDR_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_cmd       (gfc_pkg::t_cmd'(q_out[CMD_W-1:0])),
        .i_q_addr      (q_out[CMD_W +: ADDR_W]),
        .o_q_pop       (q_pop),
        .o_busy        (back_busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== sv/gfc_checker.sv =====
// Port-level checks for the compositor, bound to the top level.
// Uses gfc_pkg for the readout mode code.
module gfc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [gfc_pkg::IN_USER_W-1:0]  s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [gfc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tlast
);

    // Readout transactions accepted but not yet delivered
    logic [7:0] r_pending;
    logic       rd_in, rd_out;

    assign rd_in  = s_axis_tvalid && s_axis_tready && (s_axis_tuser == gfc_pkg::MODE_READ);
    assign rd_out = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + {7'd0, rd_in} - {7'd0, rd_out};
        end
    end

    // Reset starts the clearing pass: no input taken, no result shown
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready && !m_axis_tvalid)
        else $error("ready or valid high right after reset");

    // Every result belongs to an accepted readout
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_pending != 8'd0)
        else $error("result without a pending readout");

    // A stalled result stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    // A stalled result keeps its payload
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output payload changed while stalled");

endmodule

bind gif_frame_compositor_to_gray gfc_checker u_gfc_checker (.*);

// ===== dv/tb.sv =====
// Self-checking testbench for gif_frame_compositor_to_gray: canvas compositing and gray readout.
// Depends on gfc_pkg (sv/gfc_pkg.sv) and the top level RTL; drives stream and APB ports only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Unused mode codes sit above MODE_READ
    localparam logic [2:0] MODE_SPARE = 3'd7;
    localparam int         CANVAS_DIM = 256;
    localparam int         HOLD_OFF_CYCLES = 400;

    typedef struct {
        logic [2:0] mode;
        logic [7:0] value;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [8:0] fw;
        logic [8:0] fh;
        logic [7:0] ox;
        logic [7:0] oy;
        logic [8:0] tidx;
        logic       repl;
        logic [8:0] ncolors;
    } t_item;

    typedef struct {
        logic [7:0] gray;
        logic       last;
    } t_gray;

    typedef struct {
        t_item      it;
        bit         typed;
        logic [7:0] gray;
        logic       last;
    } t_row;

    // DUT ports
    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [gfc_pkg::APB_ADDR_W-1:0] paddr;
    logic [gfc_pkg::APB_DATA_W-1:0] pwdata;
    logic [gfc_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    // value, red, green, blue, frm_w, frm_h, offset_x, offset_y,
    // transparent_index, replace_disposal, palette_colors, zero pad
    logic [gfc_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    // mode
    logic [gfc_pkg::IN_USER_W-1:0]  s_axis_tuser;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    // gray
    logic [gfc_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    // last_pixel
    logic                           m_axis_tlast;

    gif_frame_compositor_to_gray u_dut (.*);

    // Compositor state as predicted
    logic [7:0] canvas_m [0:CANVAS_DIM*CANVAS_DIM-1];
    logic [7:0] pal_gray_m [0:255];
    logic [8:0] active_m;
    logic [8:0] fw_m, fh_m;
    logic [7:0] ox_m, oy_m;
    logic       has_key_m;
    logic [7:0] key_m;
    logic       repl_m;
    int         wx_m, wy_m, rpos_m;
    logic [8:0] cfg_w, cfg_h, cfg_bg;

    // Expected gray results, oldest first
    t_gray gray_q[$];

    int n_items = 0;
    int n_reads = 0;
    int n_clears = 0;
    int n_results = 0;
    int n_last = 0;
    int n_errors = 0;
    int burst_left = 0;
    bit gaps_on = 1'b1;
    int clears_left = 2;

    // Receiver pacing
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_cycles = 0;
    int rx_style = 0;
    int style_left = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #20ms;
        $display("FAIL gif_frame_compositor_to_gray");
        $finish;
    end

    // Canvas dimension in use: 0 reads as 1, anything past the memory clamps
    function automatic int canvas_extent(input logic [8:0] v);
        if (v == 9'd0) return 1;
        if (v > CANVAS_DIM) return CANVAS_DIM;
        return int'(v);
    endfunction

    function automatic t_item blank(input logic [2:0] mode);
        t_item it;
        it = '{mode, 8'd0, 8'd0, 8'd0, 8'd0, 9'd0, 9'd0, 8'd0, 8'd0, 9'h1FF, 1'b0, 9'd0};
        return it;
    endfunction

    function automatic t_item pal(input int idx, input int r, input int g, input int b);
        t_item it;
        it = blank(gfc_pkg::MODE_PALETTE);
        it.value = 8'(idx);
        it.red = 8'(r);
        it.green = 8'(g);
        it.blue = 8'(b);
        return it;
    endfunction

    function automatic t_item hdr(input int fw, input int fh, input int ox, input int oy,
                                  input logic [8:0] tidx, input bit repl, input int nc);
        t_item it;
        it = blank(gfc_pkg::MODE_HEADER);
        it.fw = 9'(fw);
        it.fh = 9'(fh);
        it.ox = 8'(ox);
        it.oy = 8'(oy);
        it.tidx = tidx;
        it.repl = repl;
        it.ncolors = 9'(nc);
        return it;
    endfunction

    function automatic t_item pix(input int v);
        t_item it;
        it = blank(gfc_pkg::MODE_PIXEL);
        it.value = 8'(v);
        return it;
    endfunction

    function automatic t_row row(input t_item it, input bit typed = 1'b0,
                                 input logic [7:0] g = 8'd0, input logic l = 1'b0);
        t_row r;
        r = '{it, typed, g, l};
        return r;
    endfunction

    // Every field random within its range; callers narrow what matters
    function automatic t_item rand_item(input logic [2:0] mode);
        t_item it;
        int t;
        it.mode = mode;
        it.value = 8'($urandom_range(0, 255));
        it.red = 8'($urandom_range(0, 255));
        it.green = 8'($urandom_range(0, 255));
        it.blue = 8'($urandom_range(0, 255));
        it.fw = 9'($urandom_range(0, 256));
        it.fh = 9'($urandom_range(0, 256));
        it.ox = 8'($urandom_range(0, 255));
        it.oy = 8'($urandom_range(0, 255));
        t = $urandom_range(0, 256);
        it.tidx = (t == 256) ? 9'h1FF : 9'(t);
        it.repl = 1'($urandom_range(0, 1));
        it.ncolors = 9'($urandom_range(0, 256));
        return it;
    endfunction

    // Update predicted state for one accepted item; gray readout gives a result
    task automatic composite_item(input t_item it, output bit has_res, output t_gray res);
        int cw, ch, total, cx, cy, y;
        logic [7:0] idx;
        bit keep;
        has_res = 1'b0;
        res = '{8'd0, 1'b0};
        cw = canvas_extent(cfg_w);
        ch = canvas_extent(cfg_h);
        case (it.mode)
            gfc_pkg::MODE_CLEAR: begin
                for (int i = 0; i < CANVAS_DIM * CANVAS_DIM; i++)
                    canvas_m[i] = cfg_bg[8] ? 8'd0 : cfg_bg[7:0];
                rpos_m = 0;
            end
            gfc_pkg::MODE_PALETTE: begin
                y = (19661 * int'(it.red) + 38666 * int'(it.green) + 7209 * int'(it.blue)
                     + 256) >> 16;
                pal_gray_m[it.value] = (y > 255) ? 8'd255 : 8'(y);
            end
            gfc_pkg::MODE_HEADER: begin
                fw_m = it.fw;
                fh_m = it.fh;
                ox_m = it.ox;
                oy_m = it.oy;
                has_key_m = !it.tidx[8];
                key_m = it.tidx[7:0];
                repl_m = it.repl;
                active_m = it.ncolors;
                wx_m = 0;
                wy_m = 0;
                rpos_m = 0;
            end
            gfc_pkg::MODE_PIXEL: begin
                // pixels past the frame, or of an empty frame, are ignored
                if (fw_m != 0 && fh_m != 0 && wy_m < int'(fh_m)) begin
                    cx = int'(ox_m) + wx_m;
                    cy = int'(oy_m) + wy_m;
                    keep = has_key_m && it.value == key_m && !repl_m;
                    if (cx < cw && cy < ch && !keep)
                        canvas_m[cy * CANVAS_DIM + cx] = it.value;
                    wx_m++;
                    if (wx_m >= int'(fw_m)) begin
                        wx_m = 0;
                        wy_m++;
                    end
                end
            end
            gfc_pkg::MODE_READ: begin
                total = cw * ch;
                // a shrunk canvas restarts the readout
                if (rpos_m >= total) rpos_m = 0;
                idx = canvas_m[(rpos_m / cw) * CANVAS_DIM + (rpos_m % cw)];
                res.gray = (idx < active_m) ? pal_gray_m[idx] : 8'd0;
                res.last = (rpos_m == total - 1);
                rpos_m = res.last ? 0 : rpos_m + 1;
                has_res = 1'b1;
            end
            default: ;
        endcase
    endtask

    // Offer one item in the sender's burst pattern and record what it should produce
    task automatic offer_item(input t_item it, input bit typed = 1'b0,
                              input logic [7:0] tg = 8'd0, input logic tl = 1'b0);
        bit has;
        t_gray res;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if (gaps_on && $urandom_range(0, 3) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= it.mode;
        s_axis_tdata <= {3'b000, it.ncolors, it.repl, it.tidx, it.oy, it.ox, it.fh, it.fw,
                         it.blue, it.green, it.red, it.value};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        composite_item(it, has, res);
        if (typed) begin
            res.gray = tg;
            res.last = tl;
        end
        if (has) gray_q.push_back(res);
        if (it.mode <= gfc_pkg::MODE_READ) n_items++;
        if (it.mode == gfc_pkg::MODE_READ) n_reads++;
        if (it.mode == gfc_pkg::MODE_CLEAR) n_clears++;
    endtask

    // Stop offering until every outstanding gray result is back
    task automatic drain_results(input int extra);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (gray_q.size() != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [8:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= gfc_pkg::APB_DATA_W'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            gfc_pkg::REG_CANVAS_WIDTH:  cfg_w = v;
            gfc_pkg::REG_CANVAS_HEIGHT: cfg_h = v;
            gfc_pkg::REG_BACKGROUND:    cfg_bg = v;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // One configuration's worth of random traffic, mostly whole frames and readouts
    task automatic run_phase(input int n, input bit force_clear, input bit squeeze);
        int sent0, cw, ch, act, npix, len;
        t_item it;
        sent0 = n_items;
        gaps_on = ($urandom_range(0, 3) != 0);
        cw = canvas_extent(cfg_w);
        ch = canvas_extent(cfg_h);
        // opening reads catch a readout position left past a shrunk canvas
        repeat ($urandom_range(1, 3)) offer_item(rand_item(gfc_pkg::MODE_READ));
        if (force_clear) offer_item(rand_item(gfc_pkg::MODE_CLEAR));
        if (squeeze) begin
            // receiver holds off while reads keep coming: back-pressure reaches the input
            hold_reqs++;
            gaps_on = 1'b0;
            repeat (40) offer_item(rand_item(gfc_pkg::MODE_READ));
            gaps_on = 1'b1;
        end
        while (n_items - sent0 < n) begin
            act = $urandom_range(0, 99);
            if (act < 3) begin
                offer_item(rand_item(MODE_SPARE - 3'($urandom_range(0, 2))));
            end else if (act < 5 && clears_left > 0) begin
                clears_left--;
                offer_item(rand_item(gfc_pkg::MODE_CLEAR));
            end else if (act < 18) begin
                repeat ($urandom_range(1, 4)) begin
                    it = rand_item(gfc_pkg::MODE_PALETTE);
                    if ($urandom_range(0, 3) != 0) it.value = 8'($urandom_range(0, 15));
                    if ($urandom_range(0, 7) == 0) begin
                        it.red = {8{it.red[0]}};
                        it.green = {8{it.red[0]}};
                        it.blue = {8{it.red[0]}};
                    end
                    offer_item(it);
                end
            end else if (act < 56) begin
                it = rand_item(gfc_pkg::MODE_HEADER);
                act = $urandom_range(0, 19);
                it.fw = (act == 0) ? 9'd0 : (act == 1) ? 9'd256 : 9'($urandom_range(1, 8));
                act = $urandom_range(0, 19);
                it.fh = (act == 0) ? 9'd0 : (act == 1) ? 9'd256 : 9'($urandom_range(1, 8));
                if ($urandom_range(0, 3) != 0) begin
                    it.ox = 8'($urandom_range(0, cw - 1));
                    it.oy = 8'($urandom_range(0, ch - 1));
                end
                if ($urandom_range(0, 2) != 0)
                    it.tidx = ($urandom_range(0, 2) == 0) ? 9'h1FF : 9'($urandom_range(0, 15));
                if ($urandom_range(0, 4) != 0) it.ncolors = 9'($urandom_range(0, 16));
                offer_item(it);
                npix = int'(it.fw) * int'(it.fh);
                if (npix > 64) npix = 64;
                act = $urandom_range(0, 9);
                if (act == 0) npix += $urandom_range(1, 4);           // runs past the frame
                else if (act == 1 && npix > 1) npix = $urandom_range(1, npix - 1);
                repeat (npix) begin
                    it = rand_item(gfc_pkg::MODE_PIXEL);
                    if ($urandom_range(0, 3) != 0) it.value = 8'($urandom_range(0, 15));
                    offer_item(it);
                end
            end else if (act < 97) begin
                len = cw * ch + 2;
                if (len > 48) len = 48;
                repeat ($urandom_range(1, len)) offer_item(rand_item(gfc_pkg::MODE_READ));
            end else begin
                drain_results(0);
            end
        end
        // closing read: its result proves the block has finished everything before it
        offer_item(rand_item(gfc_pkg::MODE_READ));
        drain_results(10);
    endtask

    task automatic flag_error(input string msg);
        n_errors++;
        if (n_errors <= 10) $display("mismatch: %s", msg);
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_gray e;
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            n_results++;
            if (m_axis_tlast === 1'b1) n_last++;
            if (gray_q.size() == 0) begin
                flag_error($sformatf("unexpected result gray %0d last %0b",
                                     m_axis_tdata, m_axis_tlast));
            end else begin
                e = gray_q.pop_front();
                if (m_axis_tdata !== e.gray)
                    flag_error($sformatf("result %0d gray: expected %0d, got %0d",
                                         n_results, e.gray, m_axis_tdata));
                if (m_axis_tlast !== e.last)
                    flag_error($sformatf("result %0d last_pixel: expected %0b, got %0b",
                                         n_results, e.last, m_axis_tlast));
            end
        end
    end

    // Receiver: changing stall styles plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_cycles = HOLD_OFF_CYCLES;
        end
        if (style_left == 0) begin
            rx_style = $urandom_range(0, 3);
            style_left = $urandom_range(50, 200);
        end
        style_left--;
        if (hold_cycles > 0) begin
            hold_cycles--;
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_style)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= (style_left % 4 != 0);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial begin
        t_row dir_rows[$];
        logic [8:0] ph_w[8];
        logic [8:0] ph_h[8];
        logic [8:0] ph_bg[8];

        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= '0;
        i_rst_n <= 1'b0;

        for (int i = 0; i < CANVAS_DIM * CANVAS_DIM; i++) canvas_m[i] = 8'd0;
        for (int i = 0; i < 256; i++) pal_gray_m[i] = 8'd0;
        active_m = 9'd0;
        fw_m = 9'd0;
        fh_m = 9'd0;
        ox_m = 8'd0;
        oy_m = 8'd0;
        has_key_m = 1'b0;
        key_m = 8'd0;
        repl_m = 1'b0;
        wx_m = 0;
        wy_m = 0;
        rpos_m = 0;
        cfg_w = gfc_pkg::CANVAS_WIDTH_RST;
        cfg_h = gfc_pkg::CANVAS_HEIGHT_RST;
        cfg_bg = gfc_pkg::BACKGROUND_RST;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pass on reset configuration (256x256, clear to 0)
        dir_rows = {
            row(blank(gfc_pkg::MODE_READ), 1'b1, 8'd0, 1'b0),   // all zero after reset
            row(pal(0, 255, 255, 255)),                      // white -> 255
            row(pal(255, 0, 0, 0)),                          // black, top index
            row(pal(1, 255, 0, 0)),
            row(pal(2, 0, 255, 0)),
            row(pal(3, 0, 0, 255)),
            row(hdr(2, 2, 0, 0, 9'h1FF, 1'b0, 256)),
            row(pix(0)), row(pix(1)), row(pix(2)), row(pix(3)),
            row(pix(9)),                                     // past the frame, ignored
            row(blank(gfc_pkg::MODE_READ), 1'b1, 8'd255, 1'b0),
            row(blank(gfc_pkg::MODE_READ), 1'b1, 8'd76, 1'b0),
            // corner frame: one pixel transparent, the next off canvas
            row(hdr(2, 1, 255, 255, 9'd5, 1'b0, 2)),
            row(pix(5)), row(pix(7)),
            // empty frame with no palette
            row(hdr(0, 256, 0, 0, 9'h1FF, 1'b0, 0)),
            row(pix(9)),
            row(blank(gfc_pkg::MODE_READ), 1'b1, 8'd0, 1'b0),
            // replace disposal overrides the transparent key
            row(hdr(1, 1, 0, 0, 9'd1, 1'b1, 256)),
            row(pix(1)),
            row(blank(gfc_pkg::MODE_READ), 1'b1, 8'd76, 1'b0),
            row(blank(MODE_SPARE)),
            row(blank(gfc_pkg::MODE_CLEAR)),
            row(blank(gfc_pkg::MODE_READ), 1'b1, 8'd255, 1'b0)
        };
        foreach (dir_rows[k])
            offer_item(dir_rows[k].it, dir_rows[k].typed, dir_rows[k].gray, dir_rows[k].last);
        drain_results(10);

        // Random phases: small canvases for wraparound, plus out-of-range sizes
        ph_w = '{9'd8, 9'd1, 9'd0, 9'd16, 9'd511, 9'd5, 9'd256, 9'd12};
        ph_h = '{9'd4, 9'd1, 9'd511, 9'd16, 9'd0, 9'd7, 9'd256, 9'd3};
        ph_bg = '{9'd7, 9'd255, 9'd0, 9'h1FF, 9'd3, 9'h1FF, 9'h1FF, 9'd100};
        ph_bg[5] = 9'($urandom_range(0, 255));
        ph_bg[6] = $urandom_range(0, 1) ? 9'h1FF : 9'($urandom_range(0, 255));
        for (int p = 0; p < 8; p++) begin
            write_reg(gfc_pkg::REG_CANVAS_WIDTH, ph_w[p]);
            write_reg(gfc_pkg::REG_CANVAS_HEIGHT, ph_h[p]);
            write_reg(gfc_pkg::REG_BACKGROUND, ph_bg[p]);
            run_phase(45, p == 0, p == 3);
        end

        drain_results(20);
        if (gray_q.size() != 0)
            flag_error($sformatf("%0d results never arrived", gray_q.size()));
        $display("run: %0d items over 9 settings, %0d reads, %0d clears, %0d results checked",
                 n_items, n_reads, n_clears, n_results);
        $display("run: %0d full canvas readouts ended on a last pixel, %0d mismatches",
                 n_last, n_errors);
        if (n_errors == 0) begin
            $display("PASS gif_frame_compositor_to_gray");
        end else begin
            $display("FAIL gif_frame_compositor_to_gray");
        end
        $finish;
    end

endmodule
